/* rtl/cfs_pkg.sv */
// shared constants and the crc-8 byte step for the frame synchronizer
package cfs_pkg;

  localparam int unsigned BYTE_W           = 8;
  localparam int unsigned HEADER_W         = 16;
  localparam int unsigned FRAME_DATA_W     = 64;
  localparam int unsigned DEF_FRAME_BYTES  = 8;
  localparam int unsigned DEF_HEADER_BYTES = 2;

  localparam logic [BYTE_W-1:0] CRC_POLY = 8'h07;
  localparam logic [BYTE_W-1:0] CRC_MSB  = 8'h80;

  // one byte of crc-8 (poly 0x07, msb first), input already xored with the byte
  function automatic logic [BYTE_W-1:0] crc8_byte(input logic [BYTE_W-1:0] c_in);
    logic [BYTE_W-1:0] c;
    c = c_in;
    for (int b = 0; b < BYTE_W; b++) begin
      if ((c & CRC_MSB) != '0) begin
        c = (c << 1) ^ CRC_POLY;
      end else begin
        c = c << 1;
      end
    end
    return c;
  endfunction

endpackage

/* rtl/crc_checked_frame_synchronizer.sv */
// frame synchronizer: sliding byte window, header match and crc-8 check
// Window check: a byte that triggers a check runs one crc step per window byte in ST_CRC,
//   then a decision in ST_DONE that loads the output register on a match.
// Throughput: a byte with no check is taken every cycle; a checked byte holds
//   the input off until the crc pass and the decision are done, set by the single
//   byte-wide crc unit, and longer while a frame waits on a stalled output.
// Reset: rst_ni clears the fill count, lock, frame counter, header and output valid.
module crc_checked_frame_synchronizer #(
  parameter int unsigned FRAME_BYTES  = cfs_pkg::DEF_FRAME_BYTES,
  parameter int unsigned HEADER_BYTES = cfs_pkg::DEF_HEADER_BYTES
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  // configuration: header_value
  input  logic                               cfg_we_i,
  input  logic [cfs_pkg::HEADER_W-1:0]       cfg_wdata_i,
  // input stream
  input  logic                               s_axis_tvalid_i,
  output logic                               s_axis_tready_o,
  input  logic [cfs_pkg::BYTE_W-1:0]         s_axis_tdata_i,   // [7:0] rx_byte
  // output stream
  output logic                               m_axis_tvalid_o,
  input  logic                               m_axis_tready_i,
  output logic [cfs_pkg::FRAME_DATA_W-1:0]   m_axis_tdata_o,   // [63:0] frame_data
  output logic                               m_axis_tuser_o    // [0] found_while_locked
);
  import cfs_pkg::*;

  localparam int unsigned IdxW = $clog2(FRAME_BYTES);
  localparam int unsigned CntW = $clog2(FRAME_BYTES + 1);
  localparam logic [IdxW-1:0] LastIdx = IdxW'(FRAME_BYTES - 1);
  localparam logic [CntW-1:0] FullCnt = CntW'(FRAME_BYTES);

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_CRC  = 3'b010,
    ST_DONE = 3'b100
  } state_e;

  state_e                    state_q, state_d;
  logic [BYTE_W-1:0]         win_q [FRAME_BYTES];
  logic [CntW-1:0]           fill_q, fill_d;
  logic [CntW-1:0]           bsf_q, bsf_d;
  logic                      locked_q, locked_d;
  logic [IdxW-1:0]           idx_q, idx_d;
  logic [BYTE_W-1:0]         crc_q, crc_d;
  logic [HEADER_W-1:0]       header_q;
  logic                      m_valid_q, m_valid_d;
  logic [FRAME_DATA_W-1:0]   m_data_q;
  logic                      m_user_q;

  logic                      in_acc;
  logic                      load_out;
  logic                      hdr_ok;
  logic                      win_ok;
  logic [FRAME_DATA_W-1:0]   frame_pack;
  logic [CntW-1:0]           bsf_inc;

  assign s_axis_tready_o = (state_q == ST_IDLE);
  assign in_acc          = s_axis_tvalid_i & s_axis_tready_o;
  assign bsf_inc         = bsf_q + CntW'(1);

  // header register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      header_q <= '0;
    end else if (cfg_we_i) begin
      header_q <= cfg_wdata_i;
    end
  end

  // byte window, oldest byte at index 0
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      for (int i = 0; i < FRAME_BYTES - 1; i++) begin
        win_q[i] <= win_q[i+1];
      end
      win_q[FRAME_BYTES-1] <= s_axis_tdata_i;
    end
  end

  // header compare and packed frame
  always_comb begin
    hdr_ok = 1'b1;
    for (int i = 0; i < HEADER_BYTES; i++) begin
      if (win_q[i] != header_q[BYTE_W*(HEADER_BYTES-1-i) +: BYTE_W]) begin
        hdr_ok = 1'b0;
      end
    end
    frame_pack = '0;
    for (int i = 0; i < FRAME_BYTES; i++) begin
      frame_pack[BYTE_W*(FRAME_BYTES-1-i) +: BYTE_W] = win_q[i];
    end
  end

  assign win_ok   = hdr_ok & (crc_q == '0);
  assign load_out = (state_q == ST_DONE) & win_ok & (~m_valid_q | m_axis_tready_i);

  // sequencer: shift byte in, run crc over window one byte a cycle, then decide
  always_comb begin
    state_d   = state_q;
    fill_d    = fill_q;
    bsf_d     = bsf_q;
    locked_d  = locked_q;
    idx_d     = idx_q;
    crc_d     = crc_q;
    m_valid_d = m_valid_q & ~m_axis_tready_i;
    case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          idx_d = '0;
          crc_d = '0;
          if (fill_q != FullCnt) begin
            fill_d = fill_q + CntW'(1);
          end
          if (locked_q) begin
            if (bsf_inc >= FullCnt) begin
              bsf_d   = '0;
              state_d = ST_CRC;
            end else begin
              bsf_d = bsf_inc;
            end
          end else if (fill_d == FullCnt) begin
            state_d = ST_CRC;
          end
        end
      end
      ST_CRC: begin
        crc_d = crc8_byte(crc_q ^ win_q[idx_q]);
        if (idx_q == LastIdx) begin
          state_d = ST_DONE;
        end else begin
          idx_d = idx_q + IdxW'(1);
        end
      end
      ST_DONE: begin
        if (!win_ok) begin
          locked_d = 1'b0;
          state_d  = ST_IDLE;
        end else if (load_out) begin
          m_valid_d = 1'b1;
          locked_d  = 1'b1;
          bsf_d     = '0;
          state_d   = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      fill_q    <= '0;
      bsf_q     <= '0;
      locked_q  <= 1'b0;
      idx_q     <= '0;
      crc_q     <= '0;
      m_valid_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      fill_q    <= fill_d;
      bsf_q     <= bsf_d;
      locked_q  <= locked_d;
      idx_q     <= idx_d;
      crc_q     <= crc_d;
      m_valid_q <= m_valid_d;
    end
  end

  // output register
  always_ff @(posedge clk_i) begin
    if (load_out) begin
      m_data_q <= frame_pack;
      m_user_q <= locked_q;
    end
  end

  assign m_axis_tvalid_o = m_valid_q;
  assign m_axis_tdata_o  = m_data_q;
  assign m_axis_tuser_o  = m_user_q;

  // checks
  a_crc_ends: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_CRC && idx_q == LastIdx) |=> (state_q == ST_DONE))
    else $error("crc pass did not end after the last window byte");

  a_fill_sat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q <= FullCnt)
    else $error("fill count past frame length");

  a_lock_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    locked_q |-> (fill_q == FullCnt && bsf_q < FullCnt))
    else $error("locked with partial window or bad frame counter");

  a_out_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid_o) |-> ($past(state_q) == ST_DONE))
    else $error("output raised outside the decision step");

endmodule
